FILE: rtl/sds_pkg.sv
package sds_pkg;

	localparam int unsigned COORD_W         = 16;
	localparam int unsigned TAG_W           = 16;
	localparam int unsigned SQ_W            = 2 * COORD_W;
	localparam int unsigned DIST_W          = SQ_W + 1;
	localparam int unsigned MAX_SPRITES_DEF = 64;
	localparam int unsigned CFG_IDX_W       = 1;
	localparam int unsigned CFG_DATA_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] sprite_x;
		logic [COORD_W-1:0] sprite_y;
		logic [TAG_W-1:0]   sprite_tag;
		logic               last_in;
	} item_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [TAG_W-1:0]   out_tag;
		logic [DIST_W-1:0]  out_dist;
		logic               last_out;
	} result_t;

	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [TAG_W-1:0]   tag;
		logic [DIST_W-1:0]  range_sq;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/sds_dist.sv
module sds_dist
	import sds_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               launch,
	input  item_t              item,
	input  logic [COORD_W-1:0] viewer_x,
	input  logic [COORD_W-1:0] viewer_y,
	output logic               dist_vld,
	output entry_t             ent,
	output logic               last
);

	logic               vld_s1;
	item_t              item_s1;
	logic [SQ_W-1:0]    sqx_s1;
	logic [SQ_W-1:0]    sqy_s1;
	logic               vld_s2;
	item_t              item_s2;
	logic [DIST_W-1:0]  dist_s2;
	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;

	assign dx = (viewer_x >= item.sprite_x) ? viewer_x - item.sprite_x
		: item.sprite_x - viewer_x;
	assign dy = (viewer_y >= item.sprite_y) ? viewer_y - item.sprite_y
		: item.sprite_y - viewer_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= launch;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		sqx_s1  <= dx * dx;
		sqy_s1  <= dy * dy;
		item_s2 <= item_s1;
		dist_s2 <= {1'b0, sqx_s1} + {1'b0, sqy_s1};
	end

	assign dist_vld     = vld_s2;
	assign ent.valid    = 1'b1;
	assign ent.x        = item_s2.sprite_x;
	assign ent.y        = item_s2.sprite_y;
	assign ent.tag      = item_s2.sprite_tag;
	assign ent.range_sq = dist_s2;
	assign last         = item_s2.last_in;

endmodule

FILE: rtl/sds_cell.sv
module sds_cell
	import sds_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  entry_t    new_ent,
	input  entry_t    prev_ent,
	input  logic      prev_gt,
	input  entry_t    next_ent,
	output entry_t    ent,
	output logic      gt
);

	logic   valid_q;
	entry_t data_q;
	entry_t data_d;
	logic   valid_d;

	// strict compare keeps earlier entries ahead of equal newcomers
	assign gt = !valid_q || (new_ent.range_sq > data_q.range_sq);

	always_comb begin
		data_d  = data_q;
		valid_d = valid_q;
		if (ctl.shift) begin
			data_d  = next_ent;
			valid_d = next_ent.valid;
		end else if (ctl.insert && gt) begin
			if (prev_gt) begin
				data_d  = prev_ent;
				valid_d = prev_ent.valid;
			end else begin
				data_d  = new_ent;
				valid_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	always_comb begin
		ent       = data_q;
		ent.valid = valid_q;
	end

endmodule

FILE: rtl/sprite_depth_sort.sv
// channel   | ports                           | transfer when
// ----------+---------------------------------+--------------------------
// config    | cfg_we, cfg_index, cfg_data     | cfg_we high
// sprite in | start, busy, item               | start high and busy low
// result    | result_valid, result            | result_valid high (1 cycle)
//
// a sprite passes through abs diff and squares, sum, then a sorted insert
// into the cell row (every cell compares against the new distance at once).
// after a last_in sprite the row shifts out one entry a cycle, farthest
// first, until every stored sprite is out; busy stays high throughout.
// reset clears the cell valid bits and the count; no clearing pass.
// results are strobed for one cycle and cannot be held off.
module sprite_depth_sort
	import sds_pkg::*;
#(
	parameter int unsigned MAX_SPRITES = MAX_SPRITES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  result_valid,
	output result_t               result
);

	localparam int unsigned CNT_W = $clog2(MAX_SPRITES + 1);

	state_t             state_q;
	state_t             state_d;
	logic [COORD_W-1:0] viewer_x_q;
	logic [COORD_W-1:0] viewer_y_q;
	logic [CNT_W-1:0]   count_q;
	logic               result_valid_q;
	result_t            result_q;
	logic               launch;
	logic               dist_vld;
	entry_t             new_ent;
	logic               new_last;
	logic               full;
	cell_ctl_t          ctl;
	entry_t             cell_ent [MAX_SPRITES];
	logic               cell_gt  [MAX_SPRITES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewer_x_q <= '0;
			viewer_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VIEWER_X: viewer_x_q <= cfg_data[COORD_W-1:0];
				REG_VIEWER_Y: viewer_y_q <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	sds_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.launch   (launch),
		.item     (item),
		.viewer_x (viewer_x_q),
		.viewer_y (viewer_y_q),
		.dist_vld (dist_vld),
		.ent      (new_ent),
		.last     (new_last)
	);

	assign full = (count_q == CNT_W'(MAX_SPRITES));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_CALC;
			ST_CALC: if (dist_vld) state_d = new_last ? ST_EMIT : ST_IDLE;
			ST_EMIT: if (count_q == CNT_W'(1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy       = 1'b1;
		launch     = 1'b0;
		ctl.insert = 1'b0;
		ctl.shift  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy   = 1'b0;
				launch = start;
			end
			ST_CALC: ctl.insert = dist_vld && !full;
			ST_EMIT: ctl.shift = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= ctl.shift;
			if (ctl.insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.shift) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			result_q.out_x    <= cell_ent[0].x;
			result_q.out_y    <= cell_ent[0].y;
			result_q.out_tag  <= cell_ent[0].tag;
			result_q.out_dist <= cell_ent[0].range_sq;
			result_q.last_out <= (count_q == CNT_W'(1));
		end
	end

	// cell 0 holds the farthest entry; the row stays sorted descending
	for (genvar i = 0; i < MAX_SPRITES; i++) begin : g_cell
		entry_t prev_ent;
		logic   prev_gt;
		entry_t next_ent;

		if (i == 0) begin : g_head
			assign prev_ent = '0;
			assign prev_gt  = 1'b0;
		end else begin : g_body
			assign prev_ent = cell_ent[i-1];
			assign prev_gt  = cell_gt[i-1];
		end

		if (i == MAX_SPRITES - 1) begin : g_tail
			assign next_ent = '0;
		end else begin : g_mid
			assign next_ent = cell_ent[i+1];
		end

		sds_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.new_ent  (new_ent),
			.prev_ent (prev_ent),
			.prev_gt  (prev_gt),
			.next_ent (next_ent),
			.ent      (cell_ent[i]),
			.gt       (cell_gt[i])
		);
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> count_q != '0)
		else $error("emit state with empty store");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.last_out |-> count_q == '0)
		else $error("final result while entries remain");

	a_dist_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		dist_vld |-> state_q == ST_CALC)
		else $error("distance result outside calc state");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ent[0].valid == (count_q != '0))
		else $error("head cell valid disagrees with count");

endmodule
